[hw/rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants shared by the parallel LED SPI bit encoder.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned LANES        = 4;
  localparam int unsigned PIX_W        = 24;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned GROUP_BYTES  = 48;
  localparam int unsigned CNT_W        = $clog2(GROUP_BYTES);
  localparam int unsigned CFG_DATA_W   = 3;
  localparam int unsigned CFG_IDX_W    = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LANES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_ORDER = 1'b1;

  // request types
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_GUARD  = 1'b1;

  // colour orders
  localparam logic ORDER_RGB = 1'b0;
  localparam logic ORDER_GRB = 1'b1;

  // channel slots within a group
  localparam logic [1:0] CH_FIRST  = 2'd0;
  localparam logic [1:0] CH_SECOND = 2'd1;
  localparam logic [1:0] CH_BLUE   = 2'd2;

  localparam logic [2:0] BIT_MSB = 3'd7;

  localparam logic [2:0] LANES_RESET = 3'd4;
  localparam logic       ORDER_RESET = ORDER_GRB;

  typedef struct packed {
    logic              req_type;
    logic [LANES-1:0]  lane_present;
    logic [PIX_W-1:0]  pixel_lane_a;
    logic [PIX_W-1:0]  pixel_lane_b;
    logic [PIX_W-1:0]  pixel_lane_c;
    logic [PIX_W-1:0]  pixel_lane_d;
  } ple_in_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last_byte;
  } ple_out_t;

  typedef struct packed {
    logic [2:0] lanes_in_use;
    logic       colour_order;
  } ple_cfg_t;

endpackage

[hw/rtl/ple_stream_if.sv]
// ----------------------------------------------------------------------------
// ple stream interfaces
// Valid/ready channels for pixel group requests and encoded SPI bytes.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic             valid;
  logic             ready;
  ple_pkg::ple_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ple_out_if;
  logic              valid;
  logic              ready;
  ple_pkg::ple_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/parallel_led_spi_bit_encoder.sv]
// ----------------------------------------------------------------------------
// parallel_led_spi_bit_encoder
// Transposes a four-lane pixel group into 48 SPI bytes, or emits a guard run.
//
//   channel  dir   payload                                  per item
//   in_i     sink  req_type, lane_present, pixel_lane_a..d  one request
//   out_o    src   spi_byte, last_byte                      48 or GUARD_LEN bytes
//   cfg      in    cfg_we_i, cfg_idx_i, cfg_wdata_i         one register write
//
// one byte per cycle from the position counter while out_o is not stalled;
// an encode runs 48 bytes, a guard run GUARD_LEN bytes, and the next request
// is taken in the cycle its predecessor's last byte enters the output register.
// first byte is formed from the registered request, then enters the output register.
// out_o stalls hold the output register and the counter.
// reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
module parallel_led_spi_bit_encoder #(
  parameter int unsigned MAX_LANES = 4,
  parameter int unsigned GUARD_LEN = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ple_in_if.sink                            in_i,
  ple_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [ple_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ple_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  ple_pkg::ple_cfg_t          cfg_q;
  ple_pkg::ple_in_t           item_q;
  logic                       busy_q, busy_d;
  logic [ple_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  ple_pkg::ple_out_t          out_q;
  logic                       out_valid_q, out_valid_d;
  ple_pkg::ple_out_t          gen;
  logic                       advance;
  logic                       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lanes_in_use <= ple_pkg::LANES_RESET;
      cfg_q.colour_order <= ple_pkg::ORDER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ple_pkg::CFG_LANES_IN_USE: cfg_q.lanes_in_use <= cfg_wdata_i;
        ple_pkg::CFG_COLOUR_ORDER: cfg_q.colour_order <= cfg_wdata_i[0];
      endcase
    end
  end

  ple_byte_enc #(
    .MAX_LANES (MAX_LANES),
    .GUARD_LEN (GUARD_LEN)
  ) u_byte_enc (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .pos_i  (cnt_q),
    .byte_o (gen)
  );

  assign advance    = busy_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !busy_q || (advance && gen.last_byte);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (advance) begin
      busy_d = !gen.last_byte;
      cnt_d  = gen.last_byte ? '0 : cnt_q + 1'b1;
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i.data;
    end
    if (advance) begin
      out_q <= gen;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

[hw/rtl/ple_byte_enc.sv]
// ----------------------------------------------------------------------------
// ple_byte_enc
// Forms one SPI byte of a pixel group or guard run from its byte position.
// ----------------------------------------------------------------------------
module ple_byte_enc #(
  parameter int unsigned MAX_LANES = 4,
  parameter int unsigned GUARD_LEN = 16
) (
  input  ple_pkg::ple_in_t                item_i,
  input  ple_pkg::ple_cfg_t               cfg_i,
  input  logic [ple_pkg::CNT_W-1:0]       pos_i,
  output ple_pkg::ple_out_t               byte_o
);

  logic [ple_pkg::PIX_W-1:0]  pix [ple_pkg::LANES];
  logic [ple_pkg::CHAN_W-1:0] chan [ple_pkg::LANES];
  logic [2:0]                 active;
  logic [2:0]                 bit_idx;
  logic [3:0]                 upper;
  logic [3:0]                 ones;

  assign pix[0] = item_i.pixel_lane_a;
  assign pix[1] = item_i.pixel_lane_b;
  assign pix[2] = item_i.pixel_lane_c;
  assign pix[3] = item_i.pixel_lane_d;

  assign active  = (cfg_i.lanes_in_use > 3'(MAX_LANES)) ? 3'(MAX_LANES) : cfg_i.lanes_in_use;
  assign bit_idx = ple_pkg::BIT_MSB - pos_i[3:1];

  always_comb begin
    for (int i = 0; i < ple_pkg::LANES; i++) begin
      unique case (pos_i[5:4])
        ple_pkg::CH_FIRST: begin
          chan[i] = (cfg_i.colour_order == ple_pkg::ORDER_RGB) ? pix[i][23:16] : pix[i][15:8];
        end
        ple_pkg::CH_SECOND: begin
          chan[i] = (cfg_i.colour_order == ple_pkg::ORDER_RGB) ? pix[i][15:8] : pix[i][23:16];
        end
        ple_pkg::CH_BLUE: begin
          chan[i] = pix[i][7:0];
        end
        default: begin
          chan[i] = '0;
        end
      endcase
      upper[i] = (3'(i) < active);
      ones[i]  = upper[i] & item_i.lane_present[i] & chan[i][bit_idx];
    end
  end

  always_comb begin
    if (item_i.req_type == ple_pkg::REQ_GUARD) begin
      byte_o.spi_byte  = '0;
      byte_o.last_byte = (pos_i == ple_pkg::CNT_W'(GUARD_LEN - 1));
    end else begin
      byte_o.spi_byte  = pos_i[0] ? 8'h00 : {upper, ones};
      byte_o.last_byte = (pos_i == ple_pkg::CNT_W'(ple_pkg::GROUP_BYTES - 1));
    end
  end

endmodule

[hw/rtl/ple_checker.sv]
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the encoder's byte stream, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // stalled byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled output byte changed");

  // a stalled run in progress blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while run stalled");

  // a run has no gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside a byte run");

  // every run ends on a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_byte_i == 8'h00)
    else $error("last byte not zero");

endmodule

bind parallel_led_spi_bit_encoder ple_checker u_ple_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.data.spi_byte),
  .out_last_i  (out_o.data.last_byte)
);

[dv/parallel_led_spi_bit_encoder_test.sv]
// ----------------------------------------------------------------------------
// parallel_led_spi_bit_encoder_test
// Drives pixel groups and guard requests into the encoder under several lane
// counts and colour orders, predicts each SPI byte run and checks every byte
// and its last flag in order, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module parallel_led_spi_bit_encoder_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LANES   = 4;
  localparam int unsigned GUARD_RUN   = 16;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 27;
  localparam int unsigned SETTLE      = 8;
  localparam longint      CYCLE_LIMIT = 600000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [ple_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ple_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ple_in_if  req_ch ();
  ple_out_if spi_ch ();

  logic [2:0] lanes_cfg = ple_pkg::LANES_RESET;
  logic       order_cfg = ple_pkg::ORDER_RESET;

  ple_pkg::ple_in_t  pending_groups[$];
  ple_pkg::ple_out_t bytes_due[$];
  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  int       bad_count     = 0;
  longint   cycle_count   = 0;

  parallel_led_spi_bit_encoder #(
    .MAX_LANES(MAX_LANES),
    .GUARD_LEN(GUARD_RUN)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_i(req_ch),
    .out_o(spi_ch),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [ple_pkg::CHAN_W-1:0] channel_of(
    logic [ple_pkg::PIX_W-1:0] pix, logic [1:0] slot);
    if (slot == ple_pkg::CH_BLUE) return pix[7:0];
    if ((order_cfg == ple_pkg::ORDER_RGB) == (slot == ple_pkg::CH_FIRST)) return pix[23:16];
    return pix[15:8];
  endfunction

  function automatic void encode_group(ple_pkg::ple_in_t item);
    int unsigned                 n_act;
    logic [3:0]                  mask;
    logic [3:0]                  ones;
    logic [ple_pkg::PIX_W-1:0]   pix [ple_pkg::LANES];
    logic [ple_pkg::CHAN_W-1:0]  chan;
    ple_pkg::ple_out_t           b;
    if (item.req_type == ple_pkg::REQ_GUARD) begin
      for (int k = 0; k < GUARD_RUN; k++) begin
        b.spi_byte  = 8'h00;
        b.last_byte = (k == GUARD_RUN - 1);
        bytes_due.push_back(b);
      end
      return;
    end
    n_act = (lanes_cfg > MAX_LANES) ? MAX_LANES : lanes_cfg;
    mask  = 4'((5'd1 << n_act) - 5'd1);
    pix   = '{item.pixel_lane_a, item.pixel_lane_b, item.pixel_lane_c, item.pixel_lane_d};
    for (int ch = 0; ch < 3; ch++) begin
      for (int bit_n = 7; bit_n >= 0; bit_n--) begin
        ones = 4'h0;
        for (int lane = 0; lane < n_act; lane++) begin
          chan = channel_of(pix[lane], 2'(ch));
          if (item.lane_present[lane] && chan[bit_n]) ones[lane] = 1'b1;
        end
        b.spi_byte  = {mask, ones};
        b.last_byte = 1'b0;
        bytes_due.push_back(b);
        b.spi_byte  = 8'h00;
        b.last_byte = (ch == 2 && bit_n == 0);
        bytes_due.push_back(b);
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) encode_group(req_ch.data);
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_groups.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.data  <= pending_groups.pop_front();
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ple_pkg::ple_out_t want;
    if (rst_n) begin
      if (spi_ch.valid && spi_ch.ready) begin
        if (bytes_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected byte %02h last %0b", spi_ch.data.spi_byte,
                     spi_ch.data.last_byte);
        end else begin
          want = bytes_due.pop_front();
          if (spi_ch.data.spi_byte !== want.spi_byte) begin
            bad_count++;
            if (bad_count <= 10)
              $display("spi_byte mismatch: expected %02h got %02h", want.spi_byte,
                       spi_ch.data.spi_byte);
          end
          if (spi_ch.data.last_byte !== want.last_byte) begin
            bad_count++;
            if (bad_count <= 10)
              $display("last_byte mismatch: expected %0b got %0b", want.last_byte,
                       spi_ch.data.last_byte);
          end
        end
      end
      spi_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic ple_pkg::ple_in_t pixel_group(logic [3:0] present,
                                                   logic [ple_pkg::PIX_W-1:0] a,
                                                   logic [ple_pkg::PIX_W-1:0] b,
                                                   logic [ple_pkg::PIX_W-1:0] c,
                                                   logic [ple_pkg::PIX_W-1:0] d);
    ple_pkg::ple_in_t it;
    it.req_type     = ple_pkg::REQ_ENCODE;
    it.lane_present = present;
    it.pixel_lane_a = a;
    it.pixel_lane_b = b;
    it.pixel_lane_c = c;
    it.pixel_lane_d = d;
    return it;
  endfunction

  function automatic logic [ple_pkg::PIX_W-1:0] random_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ple_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic ple_pkg::ple_in_t random_group();
    ple_pkg::ple_in_t it;
    it = pixel_group(4'($urandom_range(15)), random_pixel(), random_pixel(),
                     random_pixel(), random_pixel());
    if ($urandom_range(99) < 15) it.req_type = ple_pkg::REQ_GUARD;
    return it;
  endfunction

  task automatic drain();
    @(negedge clk);
    while (pending_groups.size() != 0 || req_ch.valid || bytes_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [ple_pkg::CFG_IDX_W-1:0] idx,
                           logic [ple_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ple_pkg::CFG_LANES_IN_USE) lanes_cfg = val;
    else order_cfg = val[0];
    @(posedge clk);
  endtask

  task automatic set_config(logic [2:0] lanes, logic order);
    write_reg(ple_pkg::CFG_LANES_IN_USE, lanes);
    write_reg(ple_pkg::CFG_COLOUR_ORDER, {2'($urandom_range(3)), order});
  endtask

  initial begin
    ple_pkg::ple_in_t guard_req;
    ple_pkg::ple_in_t colours;
    logic [2:0]  lane_sweep [PHASES];
    int          gap_sweep  [4];
    int          stall_sweep[4];
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    spi_ch.ready = 1'b0;
    lane_sweep   = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd6};
    gap_sweep    = '{0, 47, 0, 27};
    stall_sweep  = '{0, 0, 47, 27};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    guard_req = pixel_group(4'hf, '1, '1, '1, '1);
    guard_req.req_type = ple_pkg::REQ_GUARD;
    colours = pixel_group(4'hf, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'ha55ac3);

    // reset config: four lanes, grb
    pending_groups.push_back(pixel_group(4'hf, '0, '0, '0, '0));
    pending_groups.push_back(pixel_group(4'hf, '1, '1, '1, '1));
    pending_groups.push_back(pixel_group(4'h0, '1, '1, '1, '1));
    pending_groups.push_back(guard_req);
    pending_groups.push_back(colours);
    pending_groups.push_back(pixel_group(4'h1, '1, '1, '1, '1));
    pending_groups.push_back(pixel_group(4'h2, '1, '1, '1, '1));
    pending_groups.push_back(pixel_group(4'h4, '1, '1, '1, '1));
    pending_groups.push_back(pixel_group(4'h8, '1, '1, '1, '1));
    pending_groups.push_back(random_group());
    drain();

    set_config(3'd4, ple_pkg::ORDER_RGB);
    pending_groups.push_back(colours);
    pending_groups.push_back(guard_req);
    drain();
    set_config(3'd0, ple_pkg::ORDER_GRB);
    pending_groups.push_back(colours);
    pending_groups.push_back(guard_req);
    drain();
    set_config(3'd7, ple_pkg::ORDER_RGB);
    pending_groups.push_back(colours);
    drain();
    set_config(3'd2, ple_pkg::ORDER_GRB);
    pending_groups.push_back(colours);
    pending_groups.push_back(pixel_group(4'hc, '1, '1, '1, '1));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_config(lane_sweep[p], p[0]);
      send_idle_pct = gap_sweep[p % 4];
      stall_pct     = stall_sweep[p % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) pending_groups.push_back(random_group());
      drain();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    drain();
    if (bad_count == 0 && bytes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
